// File: src/wmf_pkg.sv
// Shared constants, types and helper functions of the window median filter.
package wmf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ROWS_LIMIT = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int STORE_ROWS = MAX_WINDOW - 1;
  localparam int NEWEST     = MAX_WINDOW - 2;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int POS_W      = 11;
  localparam int RAD_W      = 2;
  localparam int SEL_W      = $clog2(STORE_ROWS);
  localparam int NCELL      = MAX_WINDOW * MAX_WINDOW;
  localparam int RANK_W     = $clog2(NCELL + 1);
  localparam int NSTAGE     = PIX_W;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd2;

  typedef logic [STORE_ROWS-1:0][PIX_W-1:0] word_t;
  typedef logic [NCELL-1:0][PIX_W-1:0] cell_vec_t;
  typedef logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             med;
    logic [PIX_W-1:0] border;
    logic             eor;
    logic             eof;
  } side_t;

  typedef struct packed {
    logic             eof;
    logic             eor;
    logic [PIX_W-1:0] value;
  } out_item_t;

  // Cells of the n x n window anchored at the newest corner.
  function automatic logic [NCELL-1:0] cell_mask(input logic [RAD_W-1:0] rad);
    logic [NCELL-1:0] m;
    int base;
    base = MAX_WINDOW - 1 - 2 * int'(rad);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        m[i*MAX_WINDOW+j] = (i >= base) && (j >= base);
      end
    end
    return m;
  endfunction

  function automatic logic [RANK_W-1:0] med_rank(input logic [RAD_W-1:0] rad);
    int n;
    n = 2 * int'(rad) + 1;
    return RANK_W'((n * n - 1) >> 1);
  endfunction

endpackage

// File: src/wmf_line_store.sv
// Line store RAM: one word per column holding the previous rows, one write and two read ports.
module wmf_line_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [wmf_pkg::COL_W-1:0] wr_addr,
  input  wmf_pkg::word_t            wr_data,
  input  logic [wmf_pkg::COL_W-1:0] rd0_addr,
  output wmf_pkg::word_t            rd0_data,
  input  logic [wmf_pkg::COL_W-1:0] rd1_addr,
  output wmf_pkg::word_t            rd1_data
);

  wmf_pkg::word_t mem_r [wmf_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd0_data <= mem_r[rd0_addr];
    rd1_data <= mem_r[rd1_addr];
  end

endmodule

// File: src/wmf_median.sv
// Pipelined median select: one result bit per stage, MSB first, by rank counting.
module wmf_median (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  wmf_pkg::side_t                 in_side,
  input  wmf_pkg::cell_vec_t             cells,
  input  logic [wmf_pkg::RAD_W-1:0]      radius,
  output logic                           out_vld,
  output wmf_pkg::side_t                 out_side,
  output logic [wmf_pkg::PIX_W-1:0]      out_median
);

  localparam int NS = wmf_pkg::NSTAGE;

  logic                               vld_r   [NS+1];
  wmf_pkg::side_t                     side_r  [NS+1];
  logic [wmf_pkg::PIX_W-1:0]          res_r   [NS+1];
  wmf_pkg::cell_vec_t                 vals_r  [NS];
  logic [wmf_pkg::NCELL-1:0]          alive_r [NS];
  logic [wmf_pkg::RANK_W-1:0]         rank_r  [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0]  <= in_side;
    res_r[0]   <= '0;
    vals_r[0]  <= cells;
    alive_r[0] <= wmf_pkg::cell_mask(radius);
    rank_r[0]  <= wmf_pkg::med_rank(radius);
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int BI = wmf_pkg::PIX_W - 1 - s;
    logic [wmf_pkg::NCELL-1:0]  one_plane;
    logic [wmf_pkg::NCELL-1:0]  zero_plane;
    logic [wmf_pkg::RANK_W-1:0] zeros;
    logic                       take0;
    logic [wmf_pkg::PIX_W-1:0]  res_nxt;

    always_comb begin
      for (int i = 0; i < wmf_pkg::NCELL; i++) begin
        one_plane[i] = vals_r[s][i][BI];
      end
      zero_plane = alive_r[s] & ~one_plane;
      zeros      = wmf_pkg::RANK_W'($countones(zero_plane));
      take0      = rank_r[s] < zeros;
      res_nxt    = res_r[s];
      res_nxt[BI] = ~take0;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      side_r[s+1] <= side_r[s];
      res_r[s+1]  <= res_nxt;
    end

    if (s < NS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        vals_r[s+1]  <= vals_r[s];
        alive_r[s+1] <= take0 ? zero_plane : (alive_r[s] & one_plane);
        rank_r[s+1]  <= take0 ? rank_r[s] : (rank_r[s] - zeros);
      end
    end
  end

  assign out_vld    = vld_r[NS];
  assign out_side   = side_r[NS];
  assign out_median = res_r[NS];

endmodule

// File: src/wmf_out_fifo.sv
// Result FIFO between the filter pipeline and the output stream.
module wmf_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  wmf_pkg::out_item_t    push_data,
  input  logic                  pop,
  output wmf_pkg::out_item_t    pop_data,
  output logic                  not_empty
);

  wmf_pkg::out_item_t             buf_r [wmf_pkg::FIFO_DEPTH];
  logic [wmf_pkg::FIFO_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [wmf_pkg::FIFO_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [wmf_pkg::FIFO_AW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{wmf_pkg::FIFO_AW{1'b0}}, push} - {{wmf_pkg::FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data  = buf_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);

endmodule

// File: src/window_median_filter.sv
// Top level of the window median filter: APB registers, position control, line store RMW, window.
//
// Streaming 2-D median filter for 8-bit greyscale pixels in raster order. The block takes one
// pixel per clock while in_tready is high: each pixel does a read-modify-write of its column word
// in the line store (read, then shift and write back in the following cycle, with forwarding for
// a column hit twice in a row), then the 7x7 window shifts and an 8-stage bit-per-stage rank
// select produces the median. A result passes the stage A and stage B registers, the median
// pipeline and the result FIFO before out_tvalid rises. In item count, outputs lag the pixels
// by R*W+R, so after the last pixel of a frame the same number of flush ticks drain the rest.
// Results collect in a 16-entry FIFO; input is held off only when 16 results are owed.
// The line store needs no clearing after reset. in_tuser is the mode flag (1 = flush tick),
// out_tlast marks the end of a row and out_tuser the end of the frame.
module window_median_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] pixel_value
  input  logic                        in_tuser,   // [0] mode
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] filtered_value
  output logic                        out_tlast,  // end_of_row
  output logic                        out_tuser,  // [0] end_of_frame
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wmf_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [wmf_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [wmf_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int PW = wmf_pkg::POS_W;
  localparam int CW = wmf_pkg::COL_W;
  localparam int LW = 2 * PW + 1;

  // configuration
  logic [PW-1:0] cfg_w_r, cfg_h_r;
  logic [2:0]    cfg_ws_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= PW'(640);
      cfg_h_r  <= PW'(480);
      cfg_ws_r <= 3'd3;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        wmf_pkg::REG_FRAME_WIDTH:  cfg_w_r  <= cfg_pwdata[PW-1:0];
        wmf_pkg::REG_FRAME_HEIGHT: cfg_h_r  <= cfg_pwdata[PW-1:0];
        wmf_pkg::REG_WINDOW_SIZE:  cfg_ws_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      wmf_pkg::REG_FRAME_WIDTH:  cfg_prdata = wmf_pkg::DATA_W'(cfg_w_r);
      wmf_pkg::REG_FRAME_HEIGHT: cfg_prdata = wmf_pkg::DATA_W'(cfg_h_r);
      wmf_pkg::REG_WINDOW_SIZE:  cfg_prdata = wmf_pkg::DATA_W'(cfg_ws_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  logic [PW-1:0]               w_eff, h_eff, rad_x;
  logic [wmf_pkg::RAD_W-1:0]   rad;

  always_comb begin
    w_eff = cfg_w_r;
    if (cfg_w_r == '0) begin
      w_eff = PW'(1);
    end else if (cfg_w_r > PW'(wmf_pkg::MAX_WIDTH)) begin
      w_eff = PW'(wmf_pkg::MAX_WIDTH);
    end
    h_eff = cfg_h_r;
    if (cfg_h_r == '0) begin
      h_eff = PW'(1);
    end else if (cfg_h_r > PW'(wmf_pkg::ROWS_LIMIT)) begin
      h_eff = PW'(wmf_pkg::ROWS_LIMIT);
    end
    rad   = (cfg_ws_r == 3'd0) ? '0 : wmf_pkg::RAD_W'((cfg_ws_r - 3'd1) >> 1);
    rad_x = PW'(rad);
  end

  // position control
  logic [PW-1:0] in_col_r, in_row_r, out_col_r, out_row_r;
  logic [PW-1:0] in_col_nxt, in_row_nxt, out_col_nxt, out_row_nxt;
  logic [PW-1:0] ic0, ir0, ic_n, ir_n, ic_e, ir_e, oc0, or0, oc_n, or_n, top, diff;
  logic [LW-1:0] lin, thr;
  logic          acc, drain, pix_go, emit_try, emit_ok, clr, eor, eof, interior, bzero;
  logic [wmf_pkg::SEL_W-1:0] bsel;
  logic [wmf_pkg::FIFO_AW:0] pend_r, pend_nxt;
  logic          out_xfer;

  assign in_tready = (pend_r < (wmf_pkg::FIFO_AW+1)'(wmf_pkg::FIFO_DEPTH));
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    ic0 = in_col_r;
    ir0 = in_row_r;
    if (ic0 >= w_eff) begin
      ic0 = '0;
      ir0 = in_row_r + 1'b1;
    end
    drain    = (ir0 >= h_eff);
    pix_go   = !drain && !in_tuser;
    // raster index of this pixel against the output lag R*W+R
    lin      = LW'(ir0) * LW'(w_eff) + LW'(ic0);
    thr      = LW'(rad_x) * LW'(w_eff) + LW'(rad_x);
    emit_try = drain || (pix_go && (lin >= thr));
    ir_e     = drain ? h_eff - 1'b1 : ir0;
    ic_e     = drain ? w_eff - 1'b1 : ic0;

    ic_n = ic0;
    ir_n = ir0;
    if (pix_go) begin
      ic_n = ic0 + 1'b1;
      if (ic_n >= w_eff) begin
        ic_n = '0;
        ir_n = ir0 + 1'b1;
      end
    end

    oc0 = out_col_r;
    or0 = out_row_r;
    if (oc0 >= w_eff) begin
      oc0 = '0;
      or0 = out_row_r + 1'b1;
    end
    eor = (oc0 == w_eff - 1'b1);
    eof = eor && (or0 == h_eff - 1'b1);
    interior = (or0 >= rad_x) && (({1'b0, or0} + {1'b0, rad_x}) < {1'b0, h_eff})
            && (oc0 >= rad_x) && (({1'b0, oc0} + {1'b0, rad_x}) < {1'b0, w_eff});

    oc_n    = out_col_r;
    or_n    = out_row_r;
    emit_ok = 1'b0;
    clr     = 1'b0;
    if (emit_try) begin
      oc_n = oc0;
      or_n = or0;
      if (or0 >= h_eff) begin
        clr = 1'b1;
      end else begin
        emit_ok = 1'b1;
        if (eof) begin
          clr = 1'b1;
        end else begin
          oc_n = oc0 + 1'b1;
          if (oc_n >= w_eff) begin
            oc_n = '0;
            or_n = or0 + 1'b1;
          end
        end
      end
    end

    in_col_nxt  = clr ? '0 : ic_n;
    in_row_nxt  = clr ? '0 : ir_n;
    out_col_nxt = clr ? '0 : oc_n;
    out_row_nxt = clr ? '0 : or_n;

    // border pixel location in the line store after this item's update
    top   = ir_e;
    bzero = 1'b0;
    if (oc0 > ic_e) begin
      if (ir_e == '0) begin
        bzero = 1'b1;
      end else begin
        top = ir_e - 1'b1;
      end
    end
    if (or0 > top) begin
      bzero = 1'b1;
    end
    diff = top - or0;
    if (diff > PW'(wmf_pkg::NEWEST)) begin
      bzero = 1'b1;
    end
    bsel = bzero ? '0 : wmf_pkg::SEL_W'(PW'(wmf_pkg::NEWEST) - diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r + {{wmf_pkg::FIFO_AW{1'b0}}, acc && emit_ok}
             - {{wmf_pkg::FIFO_AW{1'b0}}, out_xfer};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // stage A: read issued, item info registered
  logic                      a_upd_r, a_emit_r, a_med_r, a_eor_r, a_eof_r, a_bzero_r;
  logic [CW-1:0]             a_col_r, a_bcol_r;
  logic [wmf_pkg::PIX_W-1:0] a_pix_r;
  logic [wmf_pkg::SEL_W-1:0] a_bsel_r;
  logic [wmf_pkg::RAD_W-1:0] a_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_upd_r  <= 1'b0;
      a_emit_r <= 1'b0;
    end else begin
      a_upd_r  <= acc && pix_go;
      a_emit_r <= acc && emit_ok;
    end
  end

  always_ff @(posedge clk) begin
    a_col_r   <= ic0[CW-1:0];
    a_bcol_r  <= oc0[CW-1:0];
    a_pix_r   <= in_tdata;
    a_med_r   <= interior;
    a_eor_r   <= eor;
    a_eof_r   <= eof;
    a_bzero_r <= bzero;
    a_bsel_r  <= bsel;
    a_rad_r   <= rad;
  end

  // stage B: line store write-back, window shift, border pick
  wmf_pkg::word_t rd0_data, rd1_data, old_word, new_word, bord_word;
  wmf_pkg::word_t wr_data_r;
  logic [CW-1:0]  wr_addr_r;
  logic           wr_vld_r;

  wmf_line_store u_store (
    .clk      (clk),
    .wr_en    (a_upd_r),
    .wr_addr  (a_col_r),
    .wr_data  (new_word),
    .rd0_addr (ic0[CW-1:0]),
    .rd0_data (rd0_data),
    .rd1_addr (oc0[CW-1:0]),
    .rd1_data (rd1_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= a_upd_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= a_col_r;
    wr_data_r <= new_word;
  end

  logic [wmf_pkg::PIX_W-1:0] border_val;

  always_comb begin
    old_word = (wr_vld_r && (wr_addr_r == a_col_r)) ? wr_data_r : rd0_data;
    new_word = {a_pix_r, old_word[wmf_pkg::STORE_ROWS-1:1]};
    if (a_upd_r && (a_bcol_r == a_col_r)) begin
      bord_word = new_word;
    end else if (wr_vld_r && (wr_addr_r == a_bcol_r)) begin
      bord_word = wr_data_r;
    end else begin
      bord_word = rd1_data;
    end
    if (a_bzero_r || (a_bsel_r >= wmf_pkg::SEL_W'(wmf_pkg::STORE_ROWS))) begin
      border_val = '0;
    end else begin
      border_val = bord_word[a_bsel_r];
    end
  end

  wmf_pkg::win_t win_r, win_nxt;

  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < wmf_pkg::MAX_WINDOW; i++) begin
      for (int k = 0; k < wmf_pkg::MAX_WINDOW - 1; k++) begin
        win_nxt[i][k] = win_r[i][k+1];
      end
    end
    for (int k = 0; k < wmf_pkg::STORE_ROWS; k++) begin
      win_nxt[k][wmf_pkg::MAX_WINDOW-1] = old_word[k];
    end
    win_nxt[wmf_pkg::MAX_WINDOW-1][wmf_pkg::MAX_WINDOW-1] = a_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_upd_r) begin
      win_r <= win_nxt;
    end
  end

  logic                      b_vld_r;
  wmf_pkg::side_t            b_side_r;
  logic [wmf_pkg::RAD_W-1:0] b_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    b_side_r <= '{med: a_med_r, border: border_val, eor: a_eor_r, eof: a_eof_r};
    b_rad_r  <= a_rad_r;
  end

  // median select and result queue
  logic                      med_vld;
  wmf_pkg::side_t            med_side;
  logic [wmf_pkg::PIX_W-1:0] med_val;
  wmf_pkg::out_item_t        push_item, pop_item;

  wmf_median u_median (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (b_vld_r),
    .in_side    (b_side_r),
    .cells      (wmf_pkg::cell_vec_t'(win_r)),
    .radius     (b_rad_r),
    .out_vld    (med_vld),
    .out_side   (med_side),
    .out_median (med_val)
  );

  assign push_item = '{eof: med_side.eof, eor: med_side.eor,
                       value: med_side.med ? med_val : med_side.border};

  wmf_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (med_vld),
    .push_data (push_item),
    .pop       (out_xfer),
    .pop_data  (pop_item),
    .not_empty (out_tvalid)
  );

  assign out_tdata = pop_item.value;
  assign out_tlast = pop_item.eor;
  assign out_tuser = pop_item.eof;

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= (wmf_pkg::FIFO_AW+1)'(wmf_pkg::FIFO_DEPTH))
    else $error("owed result count exceeds queue depth");

  a_bsel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (a_emit_r && !a_bzero_r) |-> (a_bsel_r < wmf_pkg::SEL_W'(wmf_pkg::STORE_ROWS)))
    else $error("border row select out of line store range");

  a_pend_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit_ok && !out_xfer) |=> (pend_r == $past(pend_r) + 1'b1))
    else $error("owed result count missed an accepted item");

  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("end of frame without end of row");

endmodule
